FILE: src/command_line_framer_defines.svh
// ----------------------------------------------------------------------------
// command_line_framer_defines
// Assertion macros used by the framer back end RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_FRAMER_DEFINES_SVH
`define COMMAND_LINE_FRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CMDFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CMDFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cmdfr_pkg.sv
// ----------------------------------------------------------------------------
// cmdfr_pkg
// Constants and types shared by the command line framer modules.
// ----------------------------------------------------------------------------
package cmdfr_pkg;

  localparam int MAX_FRAME = 64;
  localparam int IDX_W     = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_NL   = 8'h0A;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_HASH,
    CLS_LETTER,
    CLS_NL
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } cmd_word_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage

FILE: src/cmdfr_front.sv
// ----------------------------------------------------------------------------
// cmdfr_front
// Accepts received bytes, tags each with its class and queues it for the back.
// ----------------------------------------------------------------------------
module cmdfr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  input  logic [7:0]           rx_byte,
  output logic                 q_valid,
  input  logic                 q_ready,
  output cmdfr_pkg::cmd_word_t q_word
);
  import cmdfr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_word_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  cmd_word_t         in_word;
  logic              push;
  logic              pop;

  always_comb begin
    in_word.data = rx_byte;
    if (rx_byte == CH_HASH) begin
      in_word.cls = CLS_HASH;
    end else if (rx_byte inside {CH_G, CH_M, CH_P}) begin
      in_word.cls = CLS_LETTER;
    end else if (rx_byte == CH_NL) begin
      in_word.cls = CLS_NL;
    end else begin
      in_word.cls = CLS_OTHER;
    end
  end

  assign rx_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_word   = slots[rd_ptr];
  assign push     = rx_valid && rx_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/cmdfr_back.sv
// ----------------------------------------------------------------------------
// cmdfr_back
// Builds frames in the frame store and replays each finished frame.
// ----------------------------------------------------------------------------
`include "command_line_framer_defines.svh"

module cmdfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  cmdfr_pkg::cmd_word_t q_word,
  output logic                 frame_valid,
  input  logic                 frame_ready,
  output logic [7:0]           frame_byte,
  output logic                 frame_last,
  output logic                 has_serial_number
);
  import cmdfr_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [7:0]        frame_store [MAX_FRAME];
  logic              collecting;
  logic              collecting_next;
  logic [IDX_W-1:0]  fill_index;
  logic [IDX_W-1:0]  fill_index_next;
  logic              letter_seen;
  logic              letter_seen_next;
  logic              first_hash;
  logic              first_hash_next;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]        rd_data;
  logic              take;
  logic              full;
  logic              start_replay;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;

  assign take = q_valid && q_ready;
  assign full = (fill_index >= IDX_W'(MAX_FRAME));

  always_comb begin
    collecting_next  = collecting;
    fill_index_next  = fill_index;
    letter_seen_next = letter_seen;
    first_hash_next  = first_hash;
    start_replay     = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = '0;
    if (take) begin
      if (!collecting) begin
        if (q_word.cls == CLS_HASH || q_word.cls == CLS_LETTER) begin
          collecting_next  = 1'b1;
          letter_seen_next = (q_word.cls == CLS_LETTER);
          first_hash_next  = (q_word.cls == CLS_HASH);
          fill_index_next  = IDX_W'(1);
          mem_we           = 1'b1;
        end
      end else if (full) begin
        collecting_next = 1'b0;
      end else begin
        case (q_word.cls)
          CLS_HASH: begin
            letter_seen_next = 1'b0;
            first_hash_next  = 1'b1;
            fill_index_next  = IDX_W'(1);
            mem_we           = 1'b1;
          end
          CLS_LETTER: begin
            mem_we = 1'b1;
            if (letter_seen) begin
              first_hash_next = 1'b0;
              fill_index_next = IDX_W'(1);
            end else begin
              letter_seen_next = 1'b1;
              mem_addr         = fill_index[ADDR_W-1:0];
              fill_index_next  = fill_index + IDX_W'(1);
            end
          end
          CLS_NL: begin
            collecting_next = 1'b0;
            start_replay    = 1'b1;
          end
          default: begin
            mem_we          = 1'b1;
            mem_addr        = fill_index[ADDR_W-1:0];
            fill_index_next = fill_index + IDX_W'(1);
          end
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_RUN: begin
        if (start_replay) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (frame_ready) begin
          state_next = frame_last ? BK_RUN : BK_READ;
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  always_comb begin
    q_ready     = (state == BK_RUN);
    frame_valid = (state == BK_EMIT);
  end

  assign frame_byte        = rd_data;
  assign frame_last        = ((IDX_W'(rd_idx) + IDX_W'(1)) == fill_index);
  assign has_serial_number = first_hash;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_addr] <= q_word.data;
    end
    if (state == BK_READ) begin
      rd_data <= frame_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_RUN;
      collecting  <= 1'b0;
      fill_index  <= '0;
      letter_seen <= 1'b0;
      first_hash  <= 1'b0;
      rd_idx      <= '0;
    end else begin
      state       <= state_next;
      collecting  <= collecting_next;
      fill_index  <= fill_index_next;
      letter_seen <= letter_seen_next;
      first_hash  <= first_hash_next;
      if (start_replay) begin
        rd_idx <= '0;
      end else if (state == BK_EMIT && frame_ready && !frame_last) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

  `CMDFR_ASSERT_NOW(a_collect_fill, clk, rst, collecting,
    (fill_index != '0) && (fill_index <= IDX_W'(MAX_FRAME)),
    "collecting with an empty or overfull frame store")
  `CMDFR_ASSERT_NOW(a_replay_len, clk, rst, frame_valid,
    (fill_index != '0) && (fill_index < IDX_W'(MAX_FRAME)) && !collecting,
    "replay of a frame with bad length")
  `CMDFR_ASSERT_NOW(a_replay_idx, clk, rst, frame_valid,
    IDX_W'(rd_idx) < fill_index,
    "replay index past the frame end")
  `CMDFR_ASSERT_NEXT(a_last_done, clk, rst, frame_valid && frame_ready && frame_last,
    (state == BK_RUN) && !frame_valid,
    "replay did not finish after the last word")

endmodule

FILE: src/command_line_framer.sv
// ----------------------------------------------------------------------------
// command_line_framer
// Frames command lines from received bytes and replays each finished frame.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  rx       | in        | rx_valid / rx_ready     | rx_byte
//  frame    | out       | frame_valid/frame_ready | frame_byte, frame_last,
//           |           |                         | has_serial_number
//
// The back end takes one queued word per cycle while it builds a frame.
// A newline starts a replay of the N stored bytes; each word goes through
// BK_READ (registered frame store read), then BK_EMIT (output hold).
// A two-word queue takes up to two rx words during a replay, then rx stalls.
// Synchronous reset clears control state; the frame store is not reset.
// Stalls on the frame side hold the current word and back up into the queue.
module command_line_framer (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       frame_valid,
  input  logic       frame_ready,
  output logic [7:0] frame_byte,
  output logic       frame_last,
  output logic       has_serial_number
);
  import cmdfr_pkg::*;

  logic      q_valid;
  logic      q_ready;
  cmd_word_t q_word;

  cmdfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_word   (q_word)
  );

  cmdfr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_word            (q_word),
    .frame_valid       (frame_valid),
    .frame_ready       (frame_ready),
    .frame_byte        (frame_byte),
    .frame_last        (frame_last),
    .has_serial_number (has_serial_number)
  );

endmodule

FILE: tb/sv/tb_command_line_framer.sv
// ----------------------------------------------------------------------------
// tb_command_line_framer
// Self-checking bench: drives received bytes, rebuilds each command frame in
// a scoreboard and checks every replayed word in order, under random bursts,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_command_line_framer;
  import cmdfr_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int DRAIN_CYCLES    = 300;
  localparam int TOTAL_ITEMS     = 160;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       serial;
  } frame_word_t;

  class frame_scoreboard;
    logic              collecting;
    int                fill_count;
    logic              letter_seen;
    logic [7:0]        line_buf [MAX_FRAME];
    frame_word_t       expected_q [$];
    int                errors;

    function new();
      collecting  = 1'b0;
      fill_count  = 0;
      letter_seen = 1'b0;
      errors      = 0;
    endfunction

    static function bit is_letter(logic [7:0] b);
      return b == CH_G || b == CH_M || b == CH_P;
    endfunction

    static function bit is_start(logic [7:0] b);
      return b == CH_HASH || is_letter(b);
    endfunction

    function void open_line(logic [7:0] b);
      line_buf[0] = b;
      fill_count  = 1;
    endfunction

    // returns 0 when the word is ignored while idle
    function bit note_rx(logic [7:0] b);
      frame_word_t w;
      if (!collecting) begin
        if (is_start(b)) begin
          collecting  = 1'b1;
          letter_seen = (b != CH_HASH);
          open_line(b);
          return 1'b1;
        end
        return 1'b0;
      end
      if (fill_count >= MAX_FRAME) begin
        collecting = 1'b0;
      end else if (b == CH_HASH) begin
        letter_seen = 1'b0;
        open_line(b);
      end else if (is_letter(b)) begin
        if (letter_seen) begin
          open_line(b);
        end else begin
          letter_seen          = 1'b1;
          line_buf[fill_count] = b;
          fill_count++;
        end
      end else if (b == CH_NL) begin
        for (int i = 0; i < fill_count; i++) begin
          w.data   = line_buf[i];
          w.last   = (i + 1 == fill_count);
          w.serial = (line_buf[0] == CH_HASH);
          expected_q.push_back(w);
        end
        collecting = 1'b0;
      end else begin
        line_buf[fill_count] = b;
        fill_count++;
      end
      return 1'b1;
    endfunction

    function void check_frame(logic [7:0] d, logic l, logic s);
      frame_word_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected frame word byte=%h last=%b serial=%b", $time, d, l, s);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (d !== w.data) begin
        $display("%0t: frame_byte expected %h actual %h", $time, w.data, d);
        errors++;
      end
      if (l !== w.last) begin
        $display("%0t: frame_last expected %b actual %b", $time, w.last, l);
        errors++;
      end
      if (s !== w.serial) begin
        $display("%0t: has_serial_number expected %b actual %b", $time, w.serial, s);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       frame_valid;
  logic       frame_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_last;
  logic       has_serial_number;

  frame_scoreboard sb = new();
  int cycle_count     = 0;
  int sent_items      = 0;
  int burst_left      = 1;
  int hold_off_cycles = 0;

  command_line_framer i_dut (
    .clk               (clk),
    .rst               (rst),
    .rx_valid          (rx_valid),
    .rx_ready          (rx_ready),
    .rx_byte           (rx_byte),
    .frame_valid       (frame_valid),
    .frame_ready       (frame_ready),
    .frame_byte        (frame_byte),
    .frame_last        (frame_last),
    .has_serial_number (has_serial_number)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired", $time);
      $display("tb_command_line_framer NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_valid && frame_ready) begin
      sb.check_frame(frame_byte, frame_last, has_serial_number);
    end
  end

  initial begin : frame_sink
    logic [15:0] ready_pat;
    int          k;
    ready_pat = 16'hFFFF;
    k = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        frame_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        frame_ready <= ready_pat[k % 16];
        k++;
        if (k % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pat = 16'hFFFF;
            1: ready_pat = 16'h0001 | 16'($urandom_range(0, 16'hFFFF));
            2: ready_pat = 16'h8001;
            default: ready_pat = 16'($urandom_range(1, 16'hFFFF));
          endcase
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    void'(sb.note_rx(b));
    sent_items++;
  endtask

  task automatic idle_rx(input int n);
    rx_valid <= 1'b0;
    rx_byte  <= 8'($urandom_range(0, 255));
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] b);
    send_byte(b);
    burst_left--;
    if (burst_left <= 0) begin
      idle_rx($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  task automatic wait_drained();
    idle_rx(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_start();
    case ($urandom_range(0, 3))
      0: return CH_HASH;
      1: return CH_G;
      2: return CH_M;
      default: return CH_P;
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (frame_scoreboard::is_start(b) || b == CH_NL);
    return b;
  endfunction

  function automatic logic [7:0] content_byte();
    if ($urandom_range(0, 7) == 0) return pick_start();
    return plain_byte();
  endfunction

  task automatic send_frame(input int len, input bit terminate);
    send_item(pick_start());
    repeat (len) send_item(content_byte());
    if (terminate) send_item(CH_NL);
  endtask

  // fill the store to MAX_FRAME bytes, then send one more word
  task automatic send_full_frame(input logic [7:0] closing);
    send_item(pick_start());
    repeat (MAX_FRAME - 1) send_item(plain_byte());
    send_item(closing);
  endtask

  initial begin : stimulus
    int seq;
    int kind;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(8'h00);
    send_item(8'hFF);
    send_item(CH_NL);
    send_item(8'h41);
    send_item(CH_G);
    send_item(8'h00);
    send_item(8'hFF);
    send_item(CH_NL);
    send_item(CH_HASH);
    send_item(8'h31);
    send_item(CH_M);
    send_item(8'h78);
    send_item(CH_NL);
    send_item(CH_P);
    send_item(8'h61);
    send_item(CH_HASH);
    send_item(8'h62);
    send_item(CH_NL);
    send_item(CH_M);
    send_item(8'h71);
    send_item(CH_G);
    send_item(8'h72);
    send_item(CH_NL);
    send_item(CH_HASH);
    send_item(CH_NL);
    wait_drained();

    seq = 0;
    while (sent_items < TOTAL_ITEMS || seq < 9) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        send_frame($urandom_range(0, 10), 1'b1);
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 5)) send_item(8'($urandom_range(0, 255)));
      end else begin
        send_frame($urandom_range(0, 6), 1'b0);
      end
      seq++;
      case (seq)
        3: wait_drained();
        5: begin
          send_full_frame(CH_NL);
          send_frame(2, 1'b1);
          wait_drained();
        end
        8: begin
          hold_off_cycles = 400;
          send_byte(pick_start());
          repeat (10) send_byte(plain_byte());
          send_byte(CH_NL);
          repeat (3) begin
            send_byte(pick_start());
            send_byte(plain_byte());
            send_byte(CH_NL);
          end
        end
        default: ;
      endcase
    end

    send_item(CH_NL);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_command_line_framer OK");
    end else begin
      $display("tb_command_line_framer NOT OK");
    end
    $finish;
  end

endmodule
